// ===== src/fat12cw_pkg.sv =====
// Shared types and constants for the FAT12 cluster chain walker.
// Depends on nothing; used by the core, the sequencer and the bench.
`default_nettype none

package fat12cw_pkg;

	// FAT byte store geometry
	localparam int FAT_BYTES = 8192;
	localparam int FAT_AW    = $clog2(FAT_BYTES);

	// Field widths
	localparam int CL_W    = 12;   // cluster number / FAT12 entry
	localparam int OFF_W   = 13;   // byte offset of an entry (c*3/2 + 1 <= 6143)
	localparam int ADDR_W  = 13;   // fat_address field
	localparam int BYTE_W  = 8;
	localparam int CMD_W   = 2;
	localparam int LBA_W   = 32;
	localparam int SPC_W   = 8;
	localparam int CFG_IW  = 1;
	localparam int CFG_DW  = 32;
	localparam int IN_TW   = 40;   // 35 bits of fields, padded to bytes
	localparam int OUT_TW  = 48;   // 44 bits of fields, padded to bytes

	// Byte offsets at or above this read as zero, writes there are dropped
	localparam logic [OFF_W:0] FAT_LIMIT = (OFF_W + 1)'(FAT_BYTES);

	// Entries at or above this mark end of chain
	localparam logic [CL_W-1:0] END_MARK = 12'hFF8;

	// Register indexes on the config port
	localparam logic [CFG_IW-1:0] REG_SPC        = 1'b0;
	localparam logic [CFG_IW-1:0] REG_DATA_START = 1'b1;

	// Input command codes; code three is unused and ignored
	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE   = 2'd0,
		CMD_START   = 2'd1,
		CMD_ADVANCE = 2'd2
	} cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NEXT,   // read data holds the current cluster's entry: step to it
		ST_EMIT    // read data holds the new cluster's entry: build the result
	} seq_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] fat_address;
		logic [BYTE_W-1:0] fat_byte;
		logic [CL_W-1:0]   start_cluster;
	} in_item_t;

	typedef struct packed {
		logic [SPC_W-1:0] spc;
		logic [LBA_W-1:0] data_start;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [LBA_W-1:0] lba;
		logic [CL_W-1:0]  cluster;
		logic             last;
	} res_t;

	typedef struct packed {
		logic idle;
		logic chain_active;
	} seq_stat_t;

endpackage

`default_nettype wire

// ===== src/fat12_cluster_chain_walker_core.sv =====
// Top level of the FAT12 cluster chain walker: ports, config registers,
// output register. Depends on fat12cw_pkg and fat12cw_seq.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: command, fat_address, fat_byte, start_cluster
// m_*       out  m_tvalid/m_tready  m_tdata: lba, cluster; m_tlast: last
// cfg_*     in   cfg_valid/ready    cfg_index, cfg_data (0 sectors_per_cluster, 1 data_start_lba)
//
// A start word looks up one FAT entry, an advance word two dependent ones, each
// through a read of the synchronous FAT RAM; a write, a start on an end mark or
// an advance with no chain open needs none; an advance onto an end mark gives no result.
// Words are taken one at a time; a full output register holds the sequencer
// in its emit step for as long as it stays full.
// Reset clears control state, sets sectors per cluster to 1 and data start to 0; the FAT RAM is not cleared.
`default_nettype none

module fat12_cluster_chain_walker_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [1:0] command, [14:2] fat_address, [22:15] fat_byte, [34:23] start_cluster
	input  wire logic [fat12cw_pkg::IN_TW-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [31:0] lba, [43:32] cluster
	output logic      [fat12cw_pkg::OUT_TW-1:0]   m_tdata,
	output logic                                  m_tlast,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [fat12cw_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [fat12cw_pkg::CFG_DW-1:0]   cfg_data
);

	fat12cw_pkg::in_item_t  item;
	fat12cw_pkg::cfg_t      cfg_q;
	fat12cw_pkg::res_t      res;
	fat12cw_pkg::seq_stat_t stat;

	logic                            out_free;
	logic [fat12cw_pkg::LBA_W-1:0]   lba_q;
	logic [fat12cw_pkg::CL_W-1:0]    cluster_q;
	logic                            last_q;
	logic                            m_tvalid_q;

	// Unpack the input word
	assign item.command       = s_tdata[1:0];
	assign item.fat_address   = s_tdata[14:2];
	assign item.fat_byte      = s_tdata[22:15];
	assign item.start_cluster = s_tdata[34:23];

	// Config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spc        <= fat12cw_pkg::SPC_W'(1);
			cfg_q.data_start <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fat12cw_pkg::REG_SPC:        cfg_q.spc        <= cfg_data[fat12cw_pkg::SPC_W-1:0];
				fat12cw_pkg::REG_DATA_START: cfg_q.data_start <= cfg_data;
				default: ;
			endcase
		end
	end

	fat12cw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.cfg        (cfg_q),
		.out_free   (out_free),
		.res        (res),
		.stat       (stat)
	);

	// Output register
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			lba_q     <= res.lba;
			cluster_q <= res.cluster;
			last_q    <= res.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, cluster_q, lba_q};
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	// results come only out of a busy sequencer
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !stat.idle)
		else $error("result issued while sequencer idle");

	// a table write finishes in its own cycle
	a_write_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && item.command == fat12cw_pkg::CMD_WRITE |=> stat.idle)
		else $error("write command did not return to idle");

	// a start at end-of-chain gives nothing and closes the chain
	a_start_end: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && item.command == fat12cw_pkg::CMD_START &&
		item.start_cluster >= fat12cw_pkg::END_MARK |=> stat.idle && !stat.chain_active)
		else $error("end-of-chain start left work behind");

	// a last result closes the chain
	a_last_close: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.last |=> !stat.chain_active)
		else $error("chain still active after last result");
`endif

endmodule

`default_nettype wire

// ===== src/fat12cw_fat_ram.sv =====
// Generic byte RAM: one write port, two registered read ports.
// Standalone; sized by the instantiating module.
`default_nettype none

module fat12cw_fat_ram #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13,
	parameter int DW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr_a,
	input  wire logic [AW-1:0] raddr_b,
	output logic      [DW-1:0] rdata_a,
	output logic      [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== src/fat12cw_seq.sv =====
// Chain sequencer: decodes commands, drives the FAT RAM and builds results.
// Depends on fat12cw_pkg and fat12cw_fat_ram.
`default_nettype none

module fat12cw_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fat12cw_pkg::in_item_t item,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire fat12cw_pkg::cfg_t    cfg,
	input  wire logic                 out_free,
	output fat12cw_pkg::res_t         res,
	output fat12cw_pkg::seq_stat_t    stat
);

	fat12cw_pkg::seq_state_t         state_q, state_d;
	logic [fat12cw_pkg::CL_W-1:0]    cur_q, cur_d;
	logic                            active_q, active_d;
	logic [fat12cw_pkg::LBA_W-1:0]   prod_q, prod_d;
	logic                            odd_s1, ok_a_s1, ok_b_s1;

	logic                            accept;
	logic [fat12cw_pkg::CL_W-1:0]    rd_cl;
	logic [fat12cw_pkg::OFF_W-1:0]   off_a, off_b;
	logic                            ok_a, ok_b;
	logic                            we;
	logic [fat12cw_pkg::BYTE_W-1:0]  rdata_a, rdata_b, lo, hi;
	logic [15:0]                     word;
	logic [fat12cw_pkg::CL_W-1:0]    entry;
	logic                            last;

	assign item_ready = (state_q == fat12cw_pkg::ST_IDLE);
	assign accept     = item_valid && item_ready;

	// Cluster whose entry is looked up this cycle
	always_comb begin
		case (state_q)
			fat12cw_pkg::ST_IDLE: begin
				rd_cl = (item.command == fat12cw_pkg::CMD_START) ? item.start_cluster : cur_q;
			end
			fat12cw_pkg::ST_NEXT: rd_cl = entry;
			default:              rd_cl = cur_q;
		endcase
	end

	// Entry offset c + c/2 and the byte above it
	assign off_a = {1'b0, rd_cl} + {2'b00, rd_cl[fat12cw_pkg::CL_W-1:1]};
	assign off_b = off_a + fat12cw_pkg::OFF_W'(1);
	assign ok_a  = {1'b0, off_a} < fat12cw_pkg::FAT_LIMIT;
	assign ok_b  = {1'b0, off_b} < fat12cw_pkg::FAT_LIMIT;

	// Table writes only from an accepted write command
	assign we = accept && (item.command == fat12cw_pkg::CMD_WRITE) &&
		({1'b0, item.fat_address} < fat12cw_pkg::FAT_LIMIT);

	fat12cw_fat_ram #(
		.DEPTH (fat12cw_pkg::FAT_BYTES),
		.AW    (fat12cw_pkg::FAT_AW),
		.DW    (fat12cw_pkg::BYTE_W)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (item.fat_address[fat12cw_pkg::FAT_AW-1:0]),
		.wdata   (item.fat_byte),
		.raddr_a (off_a[fat12cw_pkg::FAT_AW-1:0]),
		.raddr_b (off_b[fat12cw_pkg::FAT_AW-1:0]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Lookup side info is registered alongside the read data
	always_ff @(posedge clk) begin
		odd_s1  <= rd_cl[0];
		ok_a_s1 <= ok_a;
		ok_b_s1 <= ok_b;
	end

	// 12-bit entry from the little-endian byte pair
	assign lo    = ok_a_s1 ? rdata_a : '0;
	assign hi    = ok_b_s1 ? rdata_b : '0;
	assign word  = {hi, lo};
	assign entry = odd_s1 ? word[15:4] : word[11:0];
	assign last  = (entry >= fat12cw_pkg::END_MARK);

	// Cluster offset times sectors per cluster, registered before the add
	assign prod_d = ({20'd0, rd_cl} - fat12cw_pkg::LBA_W'(2)) * {24'd0, cfg.spc};

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	// State and chain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fat12cw_pkg::ST_IDLE;
			cur_q    <= '0;
			active_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cur_q    <= cur_d;
			active_q <= active_d;
		end
	end

	// Next state and result
	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		active_d    = active_q;
		res.valid   = 1'b0;
		res.lba     = cfg.data_start + prod_q;
		res.cluster = cur_q;
		res.last    = last;
		case (state_q)
			fat12cw_pkg::ST_IDLE: begin
				if (accept) begin
					case (item.command)
						fat12cw_pkg::CMD_START: begin
							cur_d = item.start_cluster;
							if (item.start_cluster >= fat12cw_pkg::END_MARK) begin
								active_d = 1'b0;
							end else begin
								state_d = fat12cw_pkg::ST_EMIT;
							end
						end
						fat12cw_pkg::CMD_ADVANCE: begin
							if (active_q) begin
								state_d = fat12cw_pkg::ST_NEXT;
							end
						end
						default: ;
					endcase
				end
			end
			fat12cw_pkg::ST_NEXT: begin
				cur_d = entry;
				if (last) begin
					// table changed under the chain: end quietly
					active_d = 1'b0;
					state_d  = fat12cw_pkg::ST_IDLE;
				end else begin
					state_d = fat12cw_pkg::ST_EMIT;
				end
			end
			fat12cw_pkg::ST_EMIT: begin
				// hold here, re-reading the entry, until the output slot frees
				if (out_free) begin
					res.valid = 1'b1;
					active_d  = !last;
					state_d   = fat12cw_pkg::ST_IDLE;
				end
			end
			default: state_d = fat12cw_pkg::ST_IDLE;
		endcase
	end

	assign stat.idle         = (state_q == fat12cw_pkg::ST_IDLE);
	assign stat.chain_active = active_q;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for fat12_cluster_chain_walker_core: a directed table, then random
// chain walks with idle bursts on both streams, checked against a shadow FAT walker.
// Depends on fat12cw_pkg and the RTL in src.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fat12cw_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int SETTLE = 12;        // cycles after the last sector word before idle
	localparam int PHASE_WORDS = 280;
	localparam int PHASES = 6;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [LBA_W-1:0] lba;
		logic [CL_W-1:0]  cl;
		logic             last;
	} sector_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
		logic [CL_W-1:0]   cl;
		logic              typed;
		sector_t           res;
	} dir_row_t;

	localparam sector_t NO_SECTOR = '0;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_TW-1:0]    s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_TW-1:0]   m_tdata;
	logic                m_tlast;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [CFG_DW-1:0]   cfg_data = '0;

	fat12_cluster_chain_walker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the walker: table copy, chain position, registers
	logic [BYTE_W-1:0] shadow_fat [FAT_BYTES];
	bit                fat_written [FAT_BYTES];
	logic [CL_W-1:0]   cur_cl = '0;
	bit                in_chain = 1'b0;
	logic [SPC_W-1:0]  spc_reg = 8'd1;
	logic [LBA_W-1:0]  lba_base = '0;

	sector_t           sectors_due [$];
	logic [CL_W-1:0]   known_cl [$];    // clusters whose entries are loaded
	int unsigned       mismatches = 0;
	int unsigned       words_sent = 0;
	int unsigned       cycle_cnt = 0;
	int                gap_pct = 0;
	int                stall_pct = 0;
	int                stall_left = 0;

	// Directed words; typed sectors hold for the reset register values
	dir_row_t dir_rows [22] = '{
		// entry 0 = 0x003, entry 1 = 0xFF8, entry 2 = 0xFFF, entry 3 = 0x002
		'{CMD_WRITE, 13'd0, 8'h03, '0, 1'b0, NO_SECTOR},
		'{CMD_WRITE, 13'd1, 8'h80, '0, 1'b0, NO_SECTOR},
		'{CMD_WRITE, 13'd2, 8'hFF, '0, 1'b0, NO_SECTOR},
		'{CMD_WRITE, 13'd3, 8'hFF, '0, 1'b0, NO_SECTOR},
		'{CMD_WRITE, 13'd4, 8'h2F, '0, 1'b0, NO_SECTOR},
		'{CMD_WRITE, 13'd5, 8'h00, '0, 1'b0, NO_SECTOR},
		// advance with no chain open, unused code
		'{CMD_ADVANCE, '0, '0, '0, 1'b0, NO_SECTOR},
		'{CMD_UNUSED, '0, '0, '0, 1'b0, NO_SECTOR},
		// chain 0 -> 3 -> 2, cluster zero wraps the lba
		'{CMD_START, '0, '0, 12'd0, 1'b1, '{32'hFFFF_FFFE, 12'd0, 1'b0}},
		'{CMD_ADVANCE, '0, '0, '0, 1'b1, '{32'd1, 12'd3, 1'b0}},
		'{CMD_ADVANCE, '0, '0, '0, 1'b1, '{32'd0, 12'd2, 1'b1}},
		'{CMD_ADVANCE, '0, '0, '0, 1'b0, NO_SECTOR},
		// cluster one, start on end marks
		'{CMD_START, '0, '0, 12'd1, 1'b1, '{32'hFFFF_FFFF, 12'd1, 1'b1}},
		'{CMD_START, '0, '0, 12'hFFF, 1'b0, NO_SECTOR},
		'{CMD_START, '0, '0, 12'hFF8, 1'b0, NO_SECTOR},
		// table changed under an open chain: entry 3 becomes 0xFFF
		'{CMD_START, '0, '0, 12'd3, 1'b1, '{32'd1, 12'd3, 1'b0}},
		'{CMD_WRITE, 13'd5, 8'hFF, '0, 1'b0, NO_SECTOR},
		'{CMD_WRITE, 13'd4, 8'hFF, '0, 1'b0, NO_SECTOR},
		'{CMD_ADVANCE, '0, '0, '0, 1'b0, NO_SECTOR},
		'{CMD_ADVANCE, '0, '0, '0, 1'b0, NO_SECTOR},
		// top address, and the part of the store no entry uses
		'{CMD_WRITE, 13'h1FFF, 8'hFF, '0, 1'b0, NO_SECTOR},
		'{CMD_WRITE, 13'd6144, 8'h00, '0, 1'b0, NO_SECTOR}
	};

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned entry_offset(input logic [CL_W-1:0] c);
		return (int'(c) * 3) / 2;
	endfunction

	// 12-bit entry of cluster c from the shadow table
	function automatic logic [CL_W-1:0] fat_entry_of(input logic [CL_W-1:0] c);
		int unsigned off;
		logic [15:0] pair;
		off = entry_offset(c);
		pair = {shadow_fat[off + 1], shadow_fat[off]};
		return c[0] ? pair[15:4] : pair[11:0];
	endfunction

	function automatic bit entry_ready(input logic [CL_W-1:0] c);
		int unsigned off;
		off = entry_offset(c);
		return fat_written[off] && fat_written[off + 1];
	endfunction

	function automatic in_item_t rand_word();
		in_item_t w;
		w.command = CMD_W'($urandom_range(0, 3));
		w.fat_address = ADDR_W'($urandom_range(0, 8191));
		w.fat_byte = BYTE_W'($urandom_range(0, 255));
		w.start_cluster = CL_W'($urandom_range(0, 4095));
		return w;
	endfunction

	// Sector for the cluster just reached, or end of chain
	task automatic land_on_cluster(output bit got, output sector_t s);
		got = 1'b0;
		s = NO_SECTOR;
		if (cur_cl >= END_MARK) begin
			in_chain = 1'b0;
		end else begin
			s.lba = lba_base + (LBA_W'(cur_cl) - 32'd2) * LBA_W'(spc_reg);
			s.cl = cur_cl;
			s.last = fat_entry_of(cur_cl) >= END_MARK;
			in_chain = !s.last;
			got = 1'b1;
		end
	endtask

	// Apply one accepted word to the shadow walker
	task automatic walk_word(input in_item_t w, output bit got, output sector_t s);
		got = 1'b0;
		s = NO_SECTOR;
		case (w.command)
			CMD_WRITE: begin
				if (int'(w.fat_address) < FAT_BYTES) begin
					shadow_fat[w.fat_address] = w.fat_byte;
					fat_written[w.fat_address] = 1'b1;
				end
			end
			CMD_START: begin
				cur_cl = w.start_cluster;
				land_on_cluster(got, s);
			end
			CMD_ADVANCE: begin
				if (in_chain) begin
					cur_cl = fat_entry_of(cur_cl);
					land_on_cluster(got, s);
				end
			end
			default: ;
		endcase
	endtask

	// Drive one input word, wait for it to be taken, log what it should produce
	task automatic send_word(input in_item_t w, input bit typed, input sector_t want);
		int n;
		bit got;
		sector_t s;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			n = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TW'({w.start_cluster, w.fat_byte, w.fat_address, w.command});
		do @(posedge clk); while (!s_tready);
		walk_word(w, got, s);
		if (typed)
			sectors_due.push_back(want);
		else if (got)
			sectors_due.push_back(s);
		words_sent++;
	endtask

	// Load entry c with v, keeping the neighbor's nibble in the shared byte
	task automatic put_entry(input logic [CL_W-1:0] c, input logic [CL_W-1:0] v);
		int unsigned off;
		logic [BYTE_W-1:0] lo;
		logic [BYTE_W-1:0] hi;
		in_item_t w;
		off = entry_offset(c);
		lo = fat_written[off] ? shadow_fat[off] : BYTE_W'($urandom);
		hi = fat_written[off + 1] ? shadow_fat[off + 1] : BYTE_W'($urandom);
		if (c[0]) begin
			lo[7:4] = v[3:0];
			hi = v[11:4];
		end else begin
			lo = v[7:0];
			hi[3:0] = v[11:8];
		end
		w = rand_word();
		w.command = CMD_WRITE;
		w.fat_address = ADDR_W'(off);
		w.fat_byte = lo;
		send_word(w, 1'b0, NO_SECTOR);
		w = rand_word();
		w.command = CMD_WRITE;
		w.fat_address = ADDR_W'(off + 1);
		w.fat_byte = hi;
		send_word(w, 1'b0, NO_SECTOR);
	endtask

	// Advance only when both lookups land on loaded entries
	task automatic try_advance();
		in_item_t w;
		if (entry_ready(cur_cl) && entry_ready(fat_entry_of(cur_cl))) begin
			w = rand_word();
			w.command = CMD_ADVANCE;
			send_word(w, 1'b0, NO_SECTOR);
		end
	endtask

	// Build a random chain in the table, open it and walk it
	task automatic run_chain();
		logic [CL_W-1:0] hops [$];
		logic [CL_W-1:0] tail;
		int len;
		in_item_t w;
		len = $urandom_range(1, 8);
		repeat (len) begin
			if ($urandom_range(0, 15) == 0)
				hops.push_back(CL_W'($urandom_range(0, 1)));
			else
				hops.push_back(CL_W'($urandom_range(0, END_MARK - 1)));
		end
		// mostly an end mark, sometimes a loop back to the head
		if ($urandom_range(0, 7) == 0)
			tail = hops[0];
		else
			tail = CL_W'($urandom_range(END_MARK, 12'hFFF));
		for (int i = 0; i < len; i++)
			put_entry(hops[i], (i == len - 1) ? tail : hops[i + 1]);
		w = rand_word();
		w.command = CMD_START;
		w.start_cluster = hops[0];
		send_word(w, 1'b0, NO_SECTOR);
		foreach (hops[i])
			known_cl.push_back(hops[i]);
		while (known_cl.size() > 64)
			void'(known_cl.pop_front());
		repeat (len + $urandom_range(0, 2)) begin
			// now and then cut the chain under the walker
			if ($urandom_range(0, 11) == 0)
				put_entry(cur_cl, CL_W'($urandom_range(END_MARK, 12'hFFF)));
			try_advance();
		end
	endtask

	// A few loose words: stray writes, restarts, advances, unused code
	task automatic stir_noise();
		in_item_t w;
		repeat ($urandom_range(1, 4)) begin
			w = rand_word();
			if (w.command == CMD_ADVANCE) begin
				try_advance();
			end else begin
				if (w.command == CMD_START && !entry_ready(w.start_cluster)) begin
					if (known_cl.size() != 0)
						w.start_cluster = known_cl[$urandom_range(0, known_cl.size() - 1)];
					else
						w.start_cluster = 12'hFFF;
				end
				send_word(w, 1'b0, NO_SECTOR);
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SPC)
			spc_reg = val[SPC_W-1:0];
		else
			lba_base = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Hold the sender until every sector word is back and the core is quiet
	task automatic drain_walker();
		s_tvalid <= 1'b0;
		while (sectors_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Sector word checker and receiver stall bursts
	always @(posedge clk) begin
		sector_t seen_s;
		sector_t due_s;
		if (arst_n && m_tvalid && m_tready) begin
			seen_s.lba = m_tdata[LBA_W-1:0];
			seen_s.cl = m_tdata[LBA_W +: CL_W];
			seen_s.last = m_tlast;
			if (sectors_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected sector word: lba %h cluster %h last %b",
						seen_s.lba, seen_s.cl, seen_s.last);
			end else begin
				due_s = sectors_due.pop_front();
				if (seen_s.lba !== due_s.lba || seen_s.cl !== due_s.cl
						|| seen_s.last !== due_s.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sector mismatch: expected lba %h cluster %h last %b, got lba %h cluster %h last %b",
							due_s.lba, due_s.cl, due_s.last,
							seen_s.lba, seen_s.cl, seen_s.last);
				end
			end
		end
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog
	initial begin
		while (cycle_cnt < RUN_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		in_item_t w;
		logic [SPC_W-1:0] spc_plan [PHASES];
		logic [LBA_W-1:0] base_plan [PHASES];
		int gap_plan [PHASES];
		int stall_plan [PHASES];
		int unsigned mark;

		// register extremes first, random settings later; last phase runs with no idling
		spc_plan = '{8'd0, 8'd255, 8'd128, 8'd1, SPC_W'($urandom_range(1, 128)),
			SPC_W'($urandom_range(0, 255))};
		base_plan = '{32'hFFFF_FFFF, LBA_W'($urandom), 32'd0, 32'hFFFF_FF00,
			LBA_W'($urandom), LBA_W'($urandom)};
		gap_plan = '{20, 0, 35, 10, 25, 0};
		stall_plan = '{20, 30, 0, 10, 25, 0};

		gap_pct = 15;
		stall_pct = 15;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// entries of the end-mark clusters all read 0xFFF
		for (int a = entry_offset(END_MARK); a < entry_offset(12'hFFF) + 2; a++) begin
			w = rand_word();
			w.command = CMD_WRITE;
			w.fat_address = ADDR_W'(a);
			w.fat_byte = 8'hFF;
			send_word(w, 1'b0, NO_SECTOR);
		end

		foreach (dir_rows[i]) begin
			w = rand_word();
			w.command = dir_rows[i].cmd;
			if (dir_rows[i].cmd == CMD_WRITE) begin
				w.fat_address = dir_rows[i].addr;
				w.fat_byte = dir_rows[i].data;
			end
			if (dir_rows[i].cmd == CMD_START)
				w.start_cluster = dir_rows[i].cl;
			send_word(w, dir_rows[i].typed, dir_rows[i].res);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_walker();
			write_reg(REG_SPC, CFG_DW'(spc_plan[p]));
			write_reg(REG_DATA_START, base_plan[p]);
			gap_pct = gap_plan[p];
			stall_pct = stall_plan[p];
			mark = words_sent;
			while (words_sent - mark < PHASE_WORDS) begin
				if ($urandom_range(0, 4) != 0)
					run_chain();
				else
					stir_noise();
			end
		end
		drain_walker();

		if (mismatches == 0 && sectors_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
